@@ src/nps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Noise profile spectral subtraction package
// Shared constants, register codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int FFT_POINTS = 256;
    localparam int NUM_BINS   = (FFT_POINTS / 2) + 1;
    localparam int POS_W      = $clog2(NUM_BINS);

    localparam int PWR_W      = 32;
    localparam int CNT_W      = 16;
    localparam int STR_W      = 16;
    localparam int FRAC_BITS  = 12;
    localparam int PROD_W     = PWR_W + CNT_W;
    localparam int DIVR_W     = CNT_W + 1;
    localparam int ITER_W     = $clog2(PWR_W);

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_ENABLE       = 2'd0,
        REG_LEARN_FRAMES = 2'd1,
        REG_STRENGTH     = 2'd2,
        REG_POWER_FLOOR  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic               enable;
        logic [CNT_W-1:0]   learn_frames;
        logic [STR_W-1:0]   strength;
        logic [PWR_W-1:0]   power_floor;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic mem_rd;
        logic mul;
        logic div_start;
        logic mem_we;
        logic cmul;
        logic csub;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic learn;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

@@ src/nps_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Divides a 48-bit running sum by a 17-bit frame count, one quotient bit per
// cycle. The upper part of the dividend is known to be below the divisor, so
// only 32 steps are needed.
// ----------------------------------------------------------------------------
module nps_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [nps_pkg::PROD_W-1:0]  dividend,
    input  logic [nps_pkg::DIVR_W-1:0]  divisor,
    output logic [nps_pkg::PWR_W-1:0]   quotient,
    output logic                        done
);

    logic [nps_pkg::CNT_W-1:0]  rem_reg;
    logic [nps_pkg::PWR_W-1:0]  quo_reg;
    logic [nps_pkg::DIVR_W-1:0] dvs_reg;
    logic [nps_pkg::ITER_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [nps_pkg::DIVR_W-1:0] shifted;
    logic [nps_pkg::DIVR_W-1:0] diff;
    logic                       ge;

    assign shifted = {rem_reg, quo_reg[nps_pkg::PWR_W-1]};
    assign ge      = (shifted >= dvs_reg);
    assign diff    = shifted - dvs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == nps_pkg::ITER_W'(nps_pkg::PWR_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[nps_pkg::PROD_W-1:nps_pkg::PWR_W];
            quo_reg <= dividend[nps_pkg::PWR_W-1:0];
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            // A partial remainder stays below the divisor, so it fits in 16 bits.
            rem_reg <= ge ? diff[nps_pkg::CNT_W-1:0] : shifted[nps_pkg::CNT_W-1:0];
            quo_reg <= {quo_reg[nps_pkg::PWR_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
`endif

endmodule

@@ src/nps_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Noise profile datapath
// Holds the noise store, frame and bin counters, the multipliers, the divider
// and the output register. Steps are issued by the controller.
// ----------------------------------------------------------------------------
module nps_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  nps_pkg::cfg_t               cfg,
    input  nps_pkg::cmd_t               cmd,
    output nps_pkg::sts_t               sts,
    input  logic [nps_pkg::PWR_W-1:0]   s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [nps_pkg::PWR_W-1:0]   m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);

    // Item context
    logic [nps_pkg::PWR_W-1:0]   power_reg;
    logic                        last_reg;
    logic [nps_pkg::POS_W-1:0]   pos_reg;
    logic                        learn_reg;
    logic                        clean_reg;

    // Persistent state
    logic [nps_pkg::POS_W-1:0]   bin_pos_reg;
    logic [nps_pkg::CNT_W-1:0]   frames_reg;
    logic [nps_pkg::PWR_W-1:0]   noise_mem [nps_pkg::NUM_BINS];
    logic [nps_pkg::NUM_BINS-1:0] valid_reg;

    // Working registers
    logic [nps_pkg::PWR_W-1:0]   rd_data_reg;
    logic                        rd_valid_reg;
    logic [nps_pkg::PWR_W-1:0]   noise_reg;
    logic [nps_pkg::PROD_W-1:0]  prod_reg;
    logic [nps_pkg::PROD_W-1:0]  sub_prod_reg;
    logic [nps_pkg::PWR_W-1:0]   result_reg;

    logic                        m_valid_reg;
    logic [nps_pkg::PWR_W-1:0]   m_data_reg;
    logic                        m_last_reg;
    logic                        m_user_reg;

    logic [nps_pkg::POS_W-1:0]   pos_cur;
    logic [nps_pkg::POS_W:0]     pos_inc;
    logic [nps_pkg::POS_W-1:0]   bin_pos_next;
    logic                        learn_cur;
    logic [nps_pkg::DIVR_W-1:0]  effective;
    logic [nps_pkg::PWR_W-1:0]   noise_cur;
    logic [nps_pkg::PROD_W-1:0]  dividend;
    logic [nps_pkg::DIVR_W-1:0]  divisor;
    logic [nps_pkg::PWR_W-1:0]   quotient;
    logic                        div_done;
    logic [nps_pkg::PROD_W-nps_pkg::FRAC_BITS-1:0] sub_val;
    logic [nps_pkg::PWR_W-1:0]   diff;
    logic [nps_pkg::PWR_W-1:0]   clean_val;
    logic                        out_free;

    // Position of the arriving bin; a position past the frame folds to zero.
    assign pos_cur = (bin_pos_reg < nps_pkg::POS_W'(nps_pkg::NUM_BINS)) ? bin_pos_reg : '0;
    assign pos_inc = {1'b0, pos_cur} + 1'b1;
    always_comb begin
        if (s_tlast) begin
            bin_pos_next = '0;
        end else if (pos_inc >= (nps_pkg::POS_W + 1)'(nps_pkg::NUM_BINS)) begin
            bin_pos_next = '0;
        end else begin
            bin_pos_next = pos_inc[nps_pkg::POS_W-1:0];
        end
    end

    assign learn_cur = cfg.enable && (frames_reg < cfg.learn_frames);
    assign effective = learn_cur ? ({1'b0, frames_reg} + 1'b1) : {1'b0, frames_reg};

    assign noise_cur = rd_valid_reg ? rd_data_reg : '0;
    assign dividend  = prod_reg + {{nps_pkg::CNT_W{1'b0}}, power_reg};
    assign divisor   = {1'b0, frames_reg} + 1'b1;

    nps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    // Subtraction with floor; the subtrahend is compared at full width.
    assign sub_val = sub_prod_reg[nps_pkg::PROD_W-1:nps_pkg::FRAC_BITS];
    assign diff    = power_reg - sub_val[nps_pkg::PWR_W-1:0];
    always_comb begin
        if ({{(nps_pkg::PROD_W-nps_pkg::FRAC_BITS-nps_pkg::PWR_W){1'b0}}, power_reg}
                <= sub_val) begin
            clean_val = cfg.power_floor;
        end else if (diff < cfg.power_floor) begin
            clean_val = cfg.power_floor;
        end else begin
            clean_val = diff;
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_pos_reg <= '0;
            frames_reg  <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                bin_pos_reg <= bin_pos_next;
            end
            if (cmd.mem_we) begin
                valid_reg[pos_reg] <= 1'b1;
                if (last_reg) begin
                    frames_reg <= frames_reg + 1'b1;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            power_reg <= s_tdata;
            last_reg  <= s_tlast;
            pos_reg   <= pos_cur;
            learn_reg <= learn_cur;
            clean_reg <= cfg.enable && (effective >= {1'b0, cfg.learn_frames});
        end
        if (cmd.mul) begin
            noise_reg <= noise_cur;
            prod_reg  <= noise_cur * frames_reg;
        end
        if (cmd.mem_we) begin
            noise_reg <= quotient;
        end
        if (cmd.cmul) begin
            sub_prod_reg <= cfg.strength * noise_reg;
        end
        if (cmd.csub) begin
            result_reg <= clean_reg ? clean_val : power_reg;
        end
        if (cmd.out_load) begin
            m_data_reg <= result_reg;
            m_last_reg <= last_reg;
            m_user_reg <= learn_reg;
        end
    end

    // Noise store
    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            noise_mem[pos_reg] <= quotient;
        end
        if (cmd.mem_rd) begin
            rd_data_reg  <= noise_mem[pos_reg];
            rd_valid_reg <= valid_reg[pos_reg];
        end
    end

    assign sts.learn    = learn_reg;
    assign sts.div_done = div_done;
    assign sts.out_free = out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTH
    a_load_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("output register overwritten while a transfer is pending");
`endif

endmodule

@@ src/nps_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Noise profile controller
// Runs a bin through read, update, divide if learning, subtract and output.
// ----------------------------------------------------------------------------
module nps_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  nps_pkg::sts_t   sts,
    output nps_pkg::cmd_t   cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_READ      = 9'b000000010,
        S_MUL       = 9'b000000100,
        S_DIV_START = 9'b000001000,
        S_DIV_WAIT  = 9'b000010000,
        S_WRITE     = 9'b000100000,
        S_CMUL      = 9'b001000000,
        S_CSUB      = 9'b010000000,
        S_OUT       = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = sts.learn ? S_DIV_START : S_CMUL;
            end
            S_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (sts.div_done) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.mem_we = 1'b1;
                state_next = S_CMUL;
            end
            S_CMUL: begin
                cmd.cmul   = 1'b1;
                state_next = S_CSUB;
            end
            S_CSUB: begin
                cmd.csub   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

`ifndef SYNTH
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside the wait step");
    a_write_only_learning: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_we |-> sts.learn)
        else $error("noise store written for a bin that does not learn");
`endif

endmodule

@@ src/noise_profile_spectral_subtract_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Noise profile spectral subtraction unit
// Learns a per-bin noise mean over the first frames, then subtracts it.
// ----------------------------------------------------------------------------
// Usage:
//   Power-spectrum bins enter on the s_ channel, one bin per transfer, with
//   s_tlast on the final bin of each frame. Every bin yields exactly one
//   transfer on the m_ channel carrying the cleaned power, the frame end mark
//   and a flag telling whether the bin updated the noise profile.
//   Write settings on the APB port only while idle; the unit does not enforce it.
// Sequencing:
//   The unit works on one bin at a time. A learning bin goes from acceptance
//   through read, multiply, the 32-step divider that forms the running mean,
//   write, scaling, subtract and output steps; a bin that does not learn skips
//   the divider and the write. The next bin is taken after the output load.
// Reset:
//   aresetn is synchronous and active low. Registers return to their defaults
//   (disabled, 16 learn frames, strength 1.0, floor 1), the frame count and the
//   bin position clear, and every noise entry reads as zero via per-entry valid
//   flags, so no clearing pass is needed.
// Stalls:
//   A result waits in the output register while m_tready is low. The next bin
//   is still accepted and processed, and stops at its output step until the
//   output register frees up.
// ----------------------------------------------------------------------------
module noise_profile_spectral_subtract_unit (
    input  logic        aclk,
    input  logic        aresetn,

    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] power_in
    input  logic        s_tlast,   // last_bin

    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] power_out
    output logic        m_tlast,   // frame_end
    output logic        m_tuser,   // [0] learning

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    nps_pkg::cfg_t      cfg_reg;
    nps_pkg::cmd_t      cmd;
    nps_pkg::sts_t      sts;
    nps_pkg::reg_idx_t  reg_idx;
    logic               wr_en;

    // Registers are word aligned; the word index selects the register.
    assign reg_idx = nps_pkg::reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.learn_frames <= 16'd16;
            cfg_reg.strength     <= 16'd4096;
            cfg_reg.power_floor  <= 32'd1;
        end else if (wr_en) begin
            case (reg_idx)
                nps_pkg::REG_ENABLE:       cfg_reg.enable       <= pwdata[0];
                nps_pkg::REG_LEARN_FRAMES: cfg_reg.learn_frames <= pwdata[15:0];
                nps_pkg::REG_STRENGTH:     cfg_reg.strength     <= pwdata[15:0];
                nps_pkg::REG_POWER_FLOOR:  cfg_reg.power_floor  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // Read data follows the address combinationally.
    always_comb begin
        case (reg_idx)
            nps_pkg::REG_ENABLE:       prdata = {31'b0, cfg_reg.enable};
            nps_pkg::REG_LEARN_FRAMES: prdata = {16'b0, cfg_reg.learn_frames};
            nps_pkg::REG_STRENGTH:     prdata = {16'b0, cfg_reg.strength};
            nps_pkg::REG_POWER_FLOOR:  prdata = cfg_reg.power_floor;
            default:                   prdata = '0;
        endcase
    end

    // The controller decides when each step runs; the datapath does the work.
    nps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nps_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
